FILE: hdl/tqbps_pkg.sv
`timescale 1ns / 1ps
package tqbps_pkg;

  localparam int CHAN_FULL_SCALE_DEF = 10000;

  localparam int CHAN_W   = 16;
  localparam int MAG_W    = 15;
  localparam int PROD_W   = MAG_W + 8;
  localparam int RECIP_SH = 32;
  localparam int RECIP_W  = 26;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam int QUEUE_DEPTH = 4;
  localparam int PKT_BYTES   = 9;

  localparam logic [2:0] FMT_BASE = 3'd0;
  localparam logic [2:0] FMT_V1   = 3'd1;
  localparam logic [2:0] FMT_V2   = 3'd2;
  localparam logic [2:0] FMT_V3   = 3'd3;
  localparam logic [2:0] FMT_V4   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEATS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS = 2'd2;

  localparam logic [1:0] ACK_PENDING = 2'd0;
  localparam logic [1:0] ACK_ACKED   = 2'd1;
  localparam logic [1:0] ACK_TIMEOUT = 2'd2;

  localparam logic [1:0] ADDR_NONE = 2'd0;
  localparam logic [1:0] ADDR_BIND = 2'd1;
  localparam logic [1:0] ADDR_DATA = 2'd2;

  localparam logic [7:0] BIND_B4   = 8'h56;
  localparam logic [7:0] BIND_B5   = 8'hAA;
  localparam logic [7:0] BIND_B6   = 8'h32;
  localparam logic [7:0] BADDR_DEF = 8'h65;
  localparam logic [7:0] BADDR_V3  = 8'h64;
  localparam logic [7:0] BADDR_V4  = 8'h60;
  localparam logic [7:0] FLIP_BITS = 8'h0F;
  localparam logic [7:0] LIGHT_BIT = 8'h10;

  localparam logic [2:0]  FORMAT_RST  = FMT_BASE;
  localparam logic [7:0]  REPEATS_RST = 8'd60;
  localparam logic [31:0] ADDRESS_RST = 32'hB2C54A2F;

  typedef struct packed {
    logic [2:0]  format;
    logic [7:0]  repeats;
    logic [31:0] address;
  } cfg_t;

  typedef struct packed {
    logic                          has_pkt;
    logic [3:0]                    last_idx;
    logic [1:0]                    addr_sw;
    logic [7:0]                    bind_byte;
    logic                          short_wait;
    logic [PKT_BYTES-1:0][7:0]     bytes;
  } entry_t;

endpackage

FILE: hdl/toy_quad_bind_and_packet_sequencer.sv
`timescale 1ns / 1ps
// Transmit tick sequencer for a small quadcopter link. Each input request is one tick carrying
// the radio ack status and six stick channels; the block steps its start / bind / bind-check /
// data phase and returns either one result with no packet or the packet bytes one result at a
// time (8 for the base format, 9 with an inverted checksum otherwise), with tlast on the final
// result of the tick. The output serializer sends one byte per cycle while out_tready is high.
// Scaling runs in a three-stage front pipeline ahead of a four-entry queue, so input requests
// keep flowing while bytes drain until the queue is full. Write configuration only while the
// block is idle.
module toy_quad_bind_and_packet_sequencer #(
  parameter int CHAN_FULL_SCALE = tqbps_pkg::CHAN_FULL_SCALE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [tqbps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tqbps_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // ack_status[1:0], aileron_in[17:2], elevator_in[33:18], throttle_in[49:34],
  // rudder_in[65:50], flip_in[81:66], light_in[97:82], zero[103:98]
  input  logic [tqbps_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // packet_byte[7:0], address_switch[9:8], bind_address_byte[17:10], short_wait[18],
  // zero[23:19]
  output logic [tqbps_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                                out_tlast,
  // has_packet[0]
  output logic                                out_tuser
);
  import tqbps_pkg::*;

  cfg_t   cfg_r;
  entry_t q_in, q_head;
  logic   q_push, q_full, q_pop, q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.format  <= FORMAT_RST;
      cfg_r.repeats <= REPEATS_RST;
      cfg_r.address <= ADDRESS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FORMAT:  cfg_r.format  <= cfg_wdata[2:0];
        CFG_REPEATS: cfg_r.repeats <= cfg_wdata[7:0];
        CFG_ADDRESS: cfg_r.address <= cfg_wdata;
        default:     cfg_r         <= cfg_r;
      endcase
    end
  end

  tqbps_front #(.FULL_SCALE(CHAN_FULL_SCALE)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_in)
  );

  tqbps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_valid),
    .head       (q_head)
  );

  tqbps_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .head       (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: hdl/tqbps_scale.sv
`timescale 1ns / 1ps
module tqbps_scale #(
  parameter int FULL_SCALE = tqbps_pkg::CHAN_FULL_SCALE_DEF
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [tqbps_pkg::CHAN_W-1:0]  ch_in,
  output logic        [7:0]                    byte_out
);
  import tqbps_pkg::*;

  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'd1 << RECIP_SH) / FULL_SCALE);
  localparam logic [MAG_W-1:0]         FS     = MAG_W'(FULL_SCALE);
  localparam logic signed [CHAN_W-1:0] FS_POS = CHAN_W'(FULL_SCALE);
  localparam logic signed [CHAN_W-1:0] FS_NEG = -FS_POS;

  logic [MAG_W-1:0]          mag;
  logic [PROD_W-1:0]         x1_r, x2_r;
  logic                      neg1_r, neg2_r;
  logic [PROD_W+RECIP_W-1:0] prod;
  logic [7:0]                qe2_r, q;
  logic [PROD_W-1:0]         chk, rem;
  logic [8:0]                sval;
  logic [7:0]                byte3_r;

  always_comb begin
    if (ch_in > FS_POS || ch_in < FS_NEG) begin
      mag = FS;
    end else if (ch_in[CHAN_W-1]) begin
      mag = MAG_W'(-ch_in);
    end else begin
      mag = MAG_W'(ch_in);
    end
  end

  assign prod = (PROD_W+RECIP_W)'(x1_r) * (PROD_W+RECIP_W)'(RECIP);
  assign chk  = PROD_W'(qe2_r) * PROD_W'(FS);
  assign rem  = x2_r - chk;
  assign q    = (rem >= PROD_W'(FS)) ? qe2_r + 8'd1 : qe2_r;
  assign sval = neg2_r ? 9'd256 - {1'b0, q} : 9'd256 + {1'b0, q};

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r    <= (PROD_W'(mag) << 8) - PROD_W'(mag);
      neg1_r  <= ch_in[CHAN_W-1];
      x2_r    <= x1_r;
      neg2_r  <= neg1_r;
      qe2_r   <= prod[RECIP_SH +: 8];
      byte3_r <= sval[8:1];
    end
  end

  assign byte_out = byte3_r;

endmodule

FILE: hdl/tqbps_front.sv
`timescale 1ns / 1ps
module tqbps_front #(
  parameter int FULL_SCALE = tqbps_pkg::CHAN_FULL_SCALE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tqbps_pkg::cfg_t                     cfg,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [tqbps_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                                q_full,
  output logic                                q_push,
  output tqbps_pkg::entry_t                   q_entry
);
  import tqbps_pkg::*;

  typedef enum logic [1:0] {PH_START, PH_BIND, PH_CHECK, PH_DATA} phase_t;
  typedef enum logic [1:0] {K_NONE, K_BIND, K_CTRL} kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [1:0] addr_sw;
    logic       short_wait;
    logic [7:0] flags;
  } meta_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] flag_r, flag_nxt;
  meta_t      meta_nxt, meta1_r, meta2_r, meta3_r;
  logic       v1_r, v2_r, v3_r;
  logic       en, in_fire, pending;

  logic [1:0]               ack;
  logic signed [CHAN_W-1:0] ail, ele, thr, rud, flip, light;
  logic [7:0]               s_ail, s_ele, s_thr, s_rud;

  logic [7:0]               c_rud, c_rud_trim, c_ail;
  logic [PKT_BYTES-1:0][7:0] pkt;
  logic [7:0]               sum;

  assign ack   = in_tdata[1:0];
  assign ail   = in_tdata[17:2];
  assign ele   = in_tdata[33:18];
  assign thr   = in_tdata[49:34];
  assign rud   = in_tdata[65:50];
  assign flip  = in_tdata[81:66];
  assign light = in_tdata[97:82];

  assign en        = !v3_r || !q_full;
  assign in_tready = en;
  assign in_fire   = in_tvalid && en;
  assign pending   = (ack != ACK_ACKED) && (ack != ACK_TIMEOUT);

  always_comb begin
    phase_nxt           = phase_r;
    cnt_nxt             = cnt_r;
    meta_nxt.kind       = K_NONE;
    meta_nxt.addr_sw    = ADDR_NONE;
    meta_nxt.short_wait = 1'b0;
    case (phase_r)
      PH_START: begin
        meta_nxt.kind = K_CTRL;
        phase_nxt     = PH_CHECK;
      end
      PH_BIND: begin
        if (pending) begin
          meta_nxt.short_wait = 1'b1;
        end else if (cnt_r == 8'd0) begin
          meta_nxt.addr_sw = ADDR_DATA;
          meta_nxt.kind    = K_CTRL;
          phase_nxt        = PH_CHECK;
        end else begin
          meta_nxt.kind = K_BIND;
          cnt_nxt       = cnt_r - 8'd1;
        end
      end
      PH_CHECK: begin
        if (pending) begin
          meta_nxt.short_wait = 1'b1;
        end else if (ack == ACK_ACKED) begin
          phase_nxt = PH_DATA;
        end else begin
          meta_nxt.addr_sw = ADDR_BIND;
          meta_nxt.kind    = K_BIND;
          cnt_nxt          = cfg.repeats;
          phase_nxt        = PH_BIND;
        end
      end
      default: begin
        if (pending) meta_nxt.short_wait = 1'b1;
        else meta_nxt.kind = K_CTRL;
      end
    endcase
    if (meta_nxt.kind == K_CTRL) begin
      flag_nxt = ((flip > 0) ? FLIP_BITS : 8'h00) | ((light > 0) ? LIGHT_BIT : 8'h00);
    end else begin
      flag_nxt = flag_r;
    end
    meta_nxt.flags = flag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      cnt_r   <= 8'd0;
      flag_r  <= 8'd0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        flag_r  <= flag_nxt;
      end
      if (en) begin
        v1_r <= in_tvalid;
        v2_r <= v1_r;
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta1_r <= meta_nxt;
      meta2_r <= meta1_r;
      meta3_r <= meta2_r;
    end
  end

  tqbps_scale #(.FULL_SCALE(FULL_SCALE)) u_sc_ail (
    .clk(clk), .en(en), .ch_in(ail), .byte_out(s_ail));
  tqbps_scale #(.FULL_SCALE(FULL_SCALE)) u_sc_ele (
    .clk(clk), .en(en), .ch_in(ele), .byte_out(s_ele));
  tqbps_scale #(.FULL_SCALE(FULL_SCALE)) u_sc_thr (
    .clk(clk), .en(en), .ch_in(thr), .byte_out(s_thr));
  tqbps_scale #(.FULL_SCALE(FULL_SCALE)) u_sc_rud (
    .clk(clk), .en(en), .ch_in(rud), .byte_out(s_rud));

  always_comb begin
    c_ail = ~s_ail;
    if (cfg.format == FMT_V2) begin
      c_rud      = s_rud;
      c_rud_trim = (~s_rud) >> 1;
    end else begin
      c_rud      = ~s_rud;
      c_rud_trim = (~s_rud) >> 1;
    end
    pkt = '0;
    if (meta3_r.kind == K_BIND) begin
      pkt[0] = cfg.address[31:24];
      pkt[1] = cfg.address[23:16];
      pkt[2] = cfg.address[15:8];
      pkt[3] = cfg.address[7:0];
      pkt[4] = BIND_B4;
      pkt[5] = BIND_B5;
      pkt[6] = (cfg.format == FMT_V3) ? 8'h00 : BIND_B6;
      pkt[7] = 8'h00;
    end else begin
      pkt[0] = s_thr;
      pkt[1] = c_rud;
      pkt[3] = s_ele;
      pkt[4] = c_ail;
      if (cfg.format == FMT_BASE) begin
        pkt[2] = s_ele >> 1;
        pkt[5] = c_ail >> 1;
        pkt[6] = c_rud_trim;
      end else begin
        pkt[2] = c_rud_trim;
        pkt[5] = s_ele >> 1;
        pkt[6] = c_ail >> 1;
      end
      pkt[7] = meta3_r.flags;
    end
    sum = 8'd0;
    for (int k = 0; k < 8; k++) begin
      sum = sum + pkt[k];
    end
    pkt[8] = ~sum;

    q_entry.has_pkt    = (meta3_r.kind != K_NONE);
    q_entry.addr_sw    = meta3_r.addr_sw;
    q_entry.short_wait = meta3_r.short_wait;
    case (cfg.format)
      FMT_V4:  q_entry.bind_byte = BADDR_V4;
      FMT_V3:  q_entry.bind_byte = BADDR_V3;
      default: q_entry.bind_byte = BADDR_DEF;
    endcase
    if (meta3_r.kind == K_NONE) begin
      q_entry.last_idx = 4'd0;
      q_entry.bytes    = '0;
    end else begin
      q_entry.last_idx = (cfg.format == FMT_BASE) ? 4'd7 : 4'd8;
      q_entry.bytes    = pkt;
    end
  end

  assign q_push = v3_r && !q_full;

endmodule

FILE: hdl/tqbps_queue.sv
`timescale 1ns / 1ps
module tqbps_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tqbps_pkg::entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output tqbps_pkg::entry_t head
);
  import tqbps_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  entry_t           mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [PTR_W:0]   cnt_r;

  assign full      = (cnt_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop) rd_r <= rd_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

FILE: hdl/tqbps_back.sv
`timescale 1ns / 1ps
module tqbps_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  input  tqbps_pkg::entry_t                   head,
  output logic                                q_pop,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [tqbps_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                                out_tlast,
  output logic                                out_tuser
);
  import tqbps_pkg::*;

  logic [3:0] idx_r;
  logic       valid_r, last_r, has_r, short_r;
  logic [7:0] byte_r, baddr_r;
  logic [1:0] addr_r;
  logic       load, is_last;

  assign load    = q_valid && (!valid_r || out_tready);
  assign is_last = (idx_r == head.last_idx);
  assign q_pop   = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 4'd0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= is_last ? 4'd0 : idx_r + 4'd1;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r  <= head.bytes[idx_r];
      last_r  <= is_last;
      has_r   <= head.has_pkt;
      addr_r  <= head.addr_sw;
      baddr_r <= head.bind_byte;
      short_r <= head.short_wait;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {5'd0, short_r, baddr_r, addr_r, byte_r};
  assign out_tlast  = last_r;
  assign out_tuser  = has_r;

endmodule
